// ===== hdl/m3inv_pkg.sv =====
// Shared types, widths and cofactor table for the 3x3 matrix inverse pipeline
package m3inv_pkg;

  localparam int unsigned ElemW    = 32;
  localparam int unsigned FracBits = 16;
  localparam int unsigned NumElem  = 9;
  localparam int unsigned CofW     = 2 * ElemW + 1;
  localparam int unsigned DetW     = 3 * ElemW + 3;

  // element indices a, b, c, d of each adjugate entry a*b - c*d, row by row
  localparam logic [3:0] COF_IDX [NumElem][4] = '{
    '{4'd4, 4'd8, 4'd5, 4'd7}, '{4'd2, 4'd7, 4'd1, 4'd8}, '{4'd1, 4'd5, 4'd2, 4'd4},
    '{4'd5, 4'd6, 4'd3, 4'd8}, '{4'd0, 4'd8, 4'd2, 4'd6}, '{4'd2, 4'd3, 4'd0, 4'd5},
    '{4'd3, 4'd7, 4'd4, 4'd6}, '{4'd1, 4'd6, 4'd0, 4'd7}, '{4'd0, 4'd4, 4'd1, 4'd3}
  };

  typedef logic signed [ElemW-1:0] elem_t;
  typedef logic signed [CofW-1:0]  cof_t;

  typedef struct packed {
    logic [DetW-1:0] den;
    logic            neg;
    logic            sing;
  } det_info_t;

  typedef struct packed {
    elem_t r0c0;
    elem_t r0c1;
    elem_t r0c2;
    elem_t r1c0;
    elem_t r1c1;
    elem_t r1c2;
    elem_t r2c0;
    elem_t r2c1;
    elem_t r2c2;
  } in_word_t;

  typedef struct packed {
    elem_t i00;
    elem_t i01;
    elem_t i02;
    elem_t i10;
    elem_t i11;
    elem_t i12;
    elem_t i20;
    elem_t i21;
    elem_t i22;
    logic  singular;
  } out_word_t;

endpackage

// ===== hdl/m3inv_cof.sv =====
// Pairwise products and adjugate cofactors, two register stages
module m3inv_cof (
  input  logic                clk_i,
  input  logic                en_i,
  input  m3inv_pkg::in_word_t mat_i,
  output m3inv_pkg::cof_t     cof_o [m3inv_pkg::NumElem],
  output m3inv_pkg::elem_t    row_o [3]
);

  localparam int unsigned PW = 2 * m3inv_pkg::ElemW;

  m3inv_pkg::elem_t e [m3inv_pkg::NumElem];
  logic signed [PW-1:0] prod_q [2*m3inv_pkg::NumElem];
  m3inv_pkg::cof_t  cof_q [m3inv_pkg::NumElem];
  m3inv_pkg::elem_t row1_q [3];
  m3inv_pkg::elem_t row2_q [3];

  assign e[0] = mat_i.r0c0;
  assign e[1] = mat_i.r0c1;
  assign e[2] = mat_i.r0c2;
  assign e[3] = mat_i.r1c0;
  assign e[4] = mat_i.r1c1;
  assign e[5] = mat_i.r1c2;
  assign e[6] = mat_i.r2c0;
  assign e[7] = mat_i.r2c1;
  assign e[8] = mat_i.r2c2;

  for (genvar gi = 0; gi < m3inv_pkg::NumElem; gi++) begin : g_cof
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        prod_q[2*gi]   <= PW'(e[m3inv_pkg::COF_IDX[gi][0]]) * PW'(e[m3inv_pkg::COF_IDX[gi][1]]);
        prod_q[2*gi+1] <= PW'(e[m3inv_pkg::COF_IDX[gi][2]]) * PW'(e[m3inv_pkg::COF_IDX[gi][3]]);
        cof_q[gi]      <= m3inv_pkg::CofW'(prod_q[2*gi]) - m3inv_pkg::CofW'(prod_q[2*gi+1]);
      end
    end
    assign cof_o[gi] = cof_q[gi];
  end

  for (genvar gk = 0; gk < 3; gk++) begin : g_row
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        row1_q[gk] <= e[gk];
        row2_q[gk] <= row1_q[gk];
      end
    end
    assign row_o[gk] = row2_q[gk];
  end

endmodule

// ===== hdl/m3inv_det.sv =====
// Determinant by first-row expansion: split products, sum, magnitude
module m3inv_det (
  input  logic                 clk_i,
  input  logic                 en_i,
  input  m3inv_pkg::cof_t      cof_i [m3inv_pkg::NumElem],
  input  m3inv_pkg::elem_t     row_i [3],
  output m3inv_pkg::cof_t      cof_o [m3inv_pkg::NumElem],
  output m3inv_pkg::det_info_t info_o
);

  localparam int unsigned W  = m3inv_pkg::ElemW;
  localparam int unsigned PW = 2 * W + 1;
  localparam int unsigned DW = m3inv_pkg::DetW;

  logic signed [PW-1:0] lo_q [3];
  logic signed [PW-1:0] hi_q [3];
  logic signed [DW-1:0] det_d, det_q;
  m3inv_pkg::det_info_t info_q;
  m3inv_pkg::cof_t      cof_s_q [3][m3inv_pkg::NumElem];

  for (genvar gk = 0; gk < 3; gk++) begin : g_part
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        lo_q[gk] <= PW'(row_i[gk]) * $signed({1'b0, cof_i[3*gk][W-1:0]});
        hi_q[gk] <= PW'(row_i[gk]) * PW'($signed(cof_i[3*gk][m3inv_pkg::CofW-1:W]));
      end
    end
  end

  always_comb begin
    det_d = '0;
    for (int k = 0; k < 3; k++) begin
      det_d = det_d + (DW'(hi_q[k]) <<< W) + DW'(lo_q[k]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      det_q       <= det_d;
      info_q.den  <= det_q[DW-1] ? DW'(-det_q) : DW'(det_q);
      info_q.neg  <= det_q[DW-1];
      info_q.sing <= (det_q == '0);
    end
  end

  for (genvar gi = 0; gi < m3inv_pkg::NumElem; gi++) begin : g_dly
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        cof_s_q[0][gi] <= cof_i[gi];
        cof_s_q[1][gi] <= cof_s_q[0][gi];
        cof_s_q[2][gi] <= cof_s_q[1][gi];
      end
    end
    assign cof_o[gi] = cof_s_q[2][gi];
  end

  assign info_o = info_q;

endmodule

// ===== hdl/m3inv_div.sv =====
// Nine-lane restoring divider, one quotient bit per stage, with saturation
module m3inv_div #(
  parameter int unsigned FRAC_BITS = m3inv_pkg::FracBits
) (
  input  logic                 clk_i,
  input  logic                 en_i,
  input  m3inv_pkg::cof_t      cof_i [m3inv_pkg::NumElem],
  input  m3inv_pkg::det_info_t info_i,
  output m3inv_pkg::elem_t     res_o [m3inv_pkg::NumElem],
  output logic                 sing_o
);

  localparam int unsigned W     = m3inv_pkg::ElemW;
  localparam int unsigned CW    = m3inv_pkg::CofW;
  localparam int unsigned DW    = m3inv_pkg::DetW;
  localparam int unsigned NStep = W + 1;
  localparam int unsigned QW    = W + 1;
  localparam int unsigned NumW  = CW + 2 * FRAC_BITS;
  localparam int unsigned DivW  = DW + NStep;
  localparam int unsigned RemW  = (NumW > DivW) ? NumW : DivW;
  localparam logic [W-1:0] One  = W'(64'd1 << FRAC_BITS);
  localparam logic [QW-1:0] PosLim = (QW'(1) << (W - 1)) - QW'(1);
  localparam logic [QW-1:0] NegLim = QW'(1) << (W - 1);

  logic [RemW-1:0] num_q [m3inv_pkg::NumElem];
  logic            sgn_p_q [m3inv_pkg::NumElem];
  logic [DW-1:0]   den_p_q;
  logic            sing_p_q;

  logic [RemW-1:0] rem_q [NStep][m3inv_pkg::NumElem];
  logic [QW-1:0]   qt_q  [NStep+1][m3inv_pkg::NumElem];
  logic            sg_q  [NStep+1][m3inv_pkg::NumElem];
  logic            ov_q  [NStep+1][m3inv_pkg::NumElem];
  logic [DW-1:0]   den_q [NStep];
  logic            sing_q [NStep+1];

  m3inv_pkg::elem_t res_q [m3inv_pkg::NumElem];
  logic             sing_o_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      den_p_q   <= info_i.den;
      sing_p_q  <= info_i.sing;
      den_q[0]  <= den_p_q;
      sing_q[0] <= sing_p_q;
      sing_o_q  <= sing_q[NStep];
    end
  end

  for (genvar gl = 0; gl < m3inv_pkg::NumElem; gl++) begin : g_lane
    logic [CW-1:0] cmag;
    logic [QW-1:0] lim, mag;

    assign cmag = cof_i[gl][CW-1] ? CW'(-cof_i[gl]) : CW'(cof_i[gl]);
    assign lim  = sg_q[NStep][gl] ? NegLim : PosLim;
    assign mag  = (ov_q[NStep][gl] || (qt_q[NStep][gl] > lim)) ? lim : qt_q[NStep][gl];

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        num_q[gl]    <= RemW'(cmag) << (2 * FRAC_BITS);
        sgn_p_q[gl]  <= cof_i[gl][CW-1] ^ info_i.neg;
        rem_q[0][gl] <= num_q[gl];
        qt_q[0][gl]  <= '0;
        sg_q[0][gl]  <= sgn_p_q[gl];
        ov_q[0][gl]  <= (num_q[gl] >= (RemW'(den_p_q) << NStep));
        if (sing_q[NStep]) begin
          res_q[gl] <= ((gl % 4) == 0) ? One : '0;
        end else begin
          res_q[gl] <= sg_q[NStep][gl] ? W'(QW'(0) - mag) : W'(mag);
        end
      end
    end
    assign res_o[gl] = res_q[gl];
  end

  for (genvar gs = 1; gs <= NStep; gs++) begin : g_step
    localparam int unsigned Bit = NStep - gs;

    if (gs < NStep) begin : g_den
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          den_q[gs] <= den_q[gs-1];
        end
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        sing_q[gs] <= sing_q[gs-1];
      end
    end

    for (genvar gl = 0; gl < m3inv_pkg::NumElem; gl++) begin : g_lane
      logic [RemW:0] diff;

      assign diff = {1'b0, rem_q[gs-1][gl]} - {1'b0, RemW'(den_q[gs-1]) << Bit};

      always_ff @(posedge clk_i) begin
        if (en_i) begin
          qt_q[gs][gl] <= qt_q[gs-1][gl] | (diff[RemW] ? QW'(0) : (QW'(1) << Bit));
          sg_q[gs][gl] <= sg_q[gs-1][gl];
          ov_q[gs][gl] <= ov_q[gs-1][gl];
        end
      end

      if (gs < NStep) begin : g_rem
        always_ff @(posedge clk_i) begin
          if (en_i) begin
            rem_q[gs][gl] <= diff[RemW] ? rem_q[gs-1][gl] : diff[RemW-1:0];
          end
        end
      end
    end
  end

  assign sing_o = sing_o_q;

endmodule

// ===== hdl/matrix3x3_inverse.sv =====
// Top level of the pipelined 3x3 fixed-point matrix inverse
// Takes one matrix word per cycle and returns its adjugate inverse one word per cycle while the
// output is not stalled. The restoring divider resolves one quotient bit per stage across all
// nine elements in parallel. A singular matrix yields the identity and the singular flag. The
// whole pipe holds while a result waits at the output.
module matrix3x3_inverse #(
  parameter int unsigned FRAC_BITS = m3inv_pkg::FracBits
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  m3inv_pkg::in_word_t  in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output m3inv_pkg::out_word_t out_data_o
);

  localparam int unsigned Lat = m3inv_pkg::ElemW + 9;

  logic                 en;
  logic [Lat-1:0]       vld_d, vld_q;
  m3inv_pkg::cof_t      cof_a [m3inv_pkg::NumElem];
  m3inv_pkg::cof_t      cof_b [m3inv_pkg::NumElem];
  m3inv_pkg::elem_t     row   [3];
  m3inv_pkg::det_info_t info;
  m3inv_pkg::elem_t     res   [m3inv_pkg::NumElem];
  logic                 sing;

  assign en         = !vld_q[Lat-1] || out_ready_i;
  assign in_ready_o = en;
  assign vld_d      = {vld_q[Lat-2:0], in_valid_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= vld_d;
    end
  end

  m3inv_cof u_cof (
    .clk_i (clk_i),
    .en_i  (en),
    .mat_i (in_data_i),
    .cof_o (cof_a),
    .row_o (row)
  );

  m3inv_det u_det (
    .clk_i  (clk_i),
    .en_i   (en),
    .cof_i  (cof_a),
    .row_i  (row),
    .cof_o  (cof_b),
    .info_o (info)
  );

  m3inv_div #(
    .FRAC_BITS (FRAC_BITS)
  ) u_div (
    .clk_i  (clk_i),
    .en_i   (en),
    .cof_i  (cof_b),
    .info_i (info),
    .res_o  (res),
    .sing_o (sing)
  );

  assign out_valid_o         = vld_q[Lat-1];
  assign out_data_o.i00      = res[0];
  assign out_data_o.i01      = res[1];
  assign out_data_o.i02      = res[2];
  assign out_data_o.i10      = res[3];
  assign out_data_o.i11      = res[4];
  assign out_data_o.i12      = res[5];
  assign out_data_o.i20      = res[6];
  assign out_data_o.i21      = res[7];
  assign out_data_o.i22      = res[8];
  assign out_data_o.singular = sing;

  a_sing_identity: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.singular |->
      out_data_o.i01 == '0 && out_data_o.i02 == '0 && out_data_o.i10 == '0 &&
      out_data_o.i12 == '0 && out_data_o.i20 == '0 && out_data_o.i21 == '0 &&
      out_data_o.i00 == out_data_o.i11 && out_data_o.i11 == out_data_o.i22)
    else $error("singular word is not the identity");

  a_hold_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |=> $stable(vld_q))
    else $error("pipeline valid bits moved during a stall");

  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o && !out_ready_i)
    else $error("input held off without a waiting result");

endmodule

// ===== tb/matrix3x3_inverse_test.sv =====
// Self-checking bench for the 3x3 fixed-point matrix inverse with an exact predictor
module matrix3x3_inverse_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned NumItems = 1900;
  localparam int unsigned TailCycles = 200;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  m3inv_pkg::in_word_t in_data_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  m3inv_pkg::out_word_t out_data_o;

  m3inv_pkg::in_word_t matrix_q[$];
  m3inv_pkg::out_word_t inverse_q[$];
  int unsigned num_errors = 0;
  bit in_taken = 1'b0;
  int unsigned send_wait = 0;
  int unsigned recv_wait = 0;

  matrix3x3_inverse dut (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .in_data_i,
    .out_valid_o, .out_ready_i, .out_data_o
  );

  always #2 clk_i = ~clk_i;

  function automatic m3inv_pkg::out_word_t invert_matrix(m3inv_pkg::in_word_t m);
    logic signed [127:0] e [9];
    logic signed [127:0] det, cof, num, den, quo;
    logic signed [31:0] r [9];
    logic signed [127:0] lim_hi, lim_lo;
    m3inv_pkg::out_word_t res;
    e[0] = m.r0c0; e[1] = m.r0c1; e[2] = m.r0c2;
    e[3] = m.r1c0; e[4] = m.r1c1; e[5] = m.r1c2;
    e[6] = m.r2c0; e[7] = m.r2c1; e[8] = m.r2c2;
    det = e[0]*e[4]*e[8] + e[1]*e[5]*e[6] + e[2]*e[3]*e[7]
        - e[2]*e[4]*e[6] - e[1]*e[3]*e[8] - e[0]*e[5]*e[7];
    lim_hi = 128'sh7fffffff;
    lim_lo = -128'sh80000000;
    for (int i = 0; i < 9; i++) begin
      if (det == 0) begin
        r[i] = (i % 4 == 0) ? 32'sh10000 : 32'sh0;
      end else begin
        cof = e[m3inv_pkg::COF_IDX[i][0]] * e[m3inv_pkg::COF_IDX[i][1]]
            - e[m3inv_pkg::COF_IDX[i][2]] * e[m3inv_pkg::COF_IDX[i][3]];
        num = cof <<< (2 * m3inv_pkg::FracBits);
        den = det;
        quo = num / den;
        if (quo > lim_hi) quo = lim_hi;
        if (quo < lim_lo) quo = lim_lo;
        r[i] = quo[31:0];
      end
    end
    res = {r[0], r[1], r[2], r[3], r[4], r[5], r[6], r[7], r[8], det == 0};
    return res;
  endfunction

  function automatic m3inv_pkg::elem_t rand_elem();
    case ($urandom_range(0, 5))
      0: return m3inv_pkg::elem_t'($urandom());
      1: return m3inv_pkg::elem_t'($signed($urandom_range(0, 2 * 32'h40000)) - 32'sh40000);
      2: return m3inv_pkg::elem_t'($signed($urandom_range(0, 400)) - 200);
      3: return ($urandom_range(0, 1)) ? 32'sh7fffffff : 32'sh80000000;
      4: return m3inv_pkg::elem_t'(($signed($urandom_range(0, 16)) - 8) <<< 16);
      default: return '0;
    endcase
  endfunction

  function automatic m3inv_pkg::in_word_t rand_matrix();
    m3inv_pkg::in_word_t m;
    m = {rand_elem(), rand_elem(), rand_elem(), rand_elem(), rand_elem(),
         rand_elem(), rand_elem(), rand_elem(), rand_elem()};
    case ($urandom_range(0, 9))
      0: begin m.r1c0 = m.r0c0; m.r1c1 = m.r0c1; m.r1c2 = m.r0c2; end
      1: begin m.r2c0 = -m.r0c0; m.r2c1 = -m.r0c1; m.r2c2 = -m.r0c2; end
      2: begin m.r0c1 = 0; m.r0c2 = 0; m.r1c0 = 0; m.r1c2 = 0; m.r2c0 = 0; m.r2c1 = 0; end
      default: ;
    endcase
    return m;
  endfunction

  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (in_taken || !in_valid_i) begin
        if (in_taken) begin
          send_wait = $urandom_range(0, 17);
        end
        if (send_wait == 0 && matrix_q.size() != 0) begin
          in_data_i <= matrix_q.pop_front();
          in_valid_i <= 1'b1;
        end else begin
          if (send_wait != 0) send_wait--;
          in_valid_i <= 1'b0;
        end
      end
      if (recv_wait != 0) begin
        recv_wait--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      in_taken = in_valid_i && in_ready_o;
      if (in_taken) inverse_q.push_back(invert_matrix(in_data_i));
      if (out_valid_o && out_ready_i) begin
        recv_wait = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 17) : 0;
        if (inverse_q.size() == 0) begin
          $error("unexpected result word %h", out_data_o);
          num_errors++;
        end else begin
          m3inv_pkg::out_word_t x;
          x = inverse_q.pop_front();
          if (x.i00 !== out_data_o.i00) begin
            $error("i00 exp %h got %h", x.i00, out_data_o.i00); num_errors++;
          end
          if (x.i01 !== out_data_o.i01) begin
            $error("i01 exp %h got %h", x.i01, out_data_o.i01); num_errors++;
          end
          if (x.i02 !== out_data_o.i02) begin
            $error("i02 exp %h got %h", x.i02, out_data_o.i02); num_errors++;
          end
          if (x.i10 !== out_data_o.i10) begin
            $error("i10 exp %h got %h", x.i10, out_data_o.i10); num_errors++;
          end
          if (x.i11 !== out_data_o.i11) begin
            $error("i11 exp %h got %h", x.i11, out_data_o.i11); num_errors++;
          end
          if (x.i12 !== out_data_o.i12) begin
            $error("i12 exp %h got %h", x.i12, out_data_o.i12); num_errors++;
          end
          if (x.i20 !== out_data_o.i20) begin
            $error("i20 exp %h got %h", x.i20, out_data_o.i20); num_errors++;
          end
          if (x.i21 !== out_data_o.i21) begin
            $error("i21 exp %h got %h", x.i21, out_data_o.i21); num_errors++;
          end
          if (x.i22 !== out_data_o.i22) begin
            $error("i22 exp %h got %h", x.i22, out_data_o.i22); num_errors++;
          end
          if (x.singular !== out_data_o.singular) begin
            $error("singular exp %b got %b", x.singular, out_data_o.singular);
            num_errors++;
          end
        end
      end
    end
  end

  initial begin
    m3inv_pkg::in_word_t m;
    m = '0;
    matrix_q.push_back(m);
    m.r0c0 = 32'sh10000; m.r1c1 = 32'sh10000; m.r2c2 = 32'sh10000;
    matrix_q.push_back(m);
    m.r0c0 = 32'sh1; m.r1c1 = 32'sh1; m.r2c2 = 32'sh1;
    matrix_q.push_back(m);
    m.r0c0 = 32'sh7fffffff; m.r1c1 = 32'sh7fffffff; m.r2c2 = 32'sh7fffffff;
    matrix_q.push_back(m);
    m.r0c0 = 32'sh80000000; m.r1c1 = 32'sh80000000; m.r2c2 = 32'sh80000000;
    matrix_q.push_back(m);
    m.r0c0 = -32'sh10000; m.r1c1 = 32'sh10000; m.r2c2 = 32'sh1;
    matrix_q.push_back(m);
    matrix_q.push_back('1);
    matrix_q.push_back({9{32'sh80000000}});
    matrix_q.push_back({9{32'sh7fffffff}});
    matrix_q.push_back({32'sh7fffffff, 32'sh80000000, 32'sh7fffffff, 32'sh80000000,
                        32'sh7fffffff, 32'sh80000000, 32'sh7fffffff, 32'sh80000000,
                        32'sh7fffffff});
    matrix_q.push_back({32'sh20000, 32'sh10000, 32'sh0, 32'sh10000, 32'sh30000,
                        32'sh10000, 32'sh0, 32'sh10000, 32'sh40000});
    matrix_q.push_back({32'sh1, 32'sh2, 32'sh3, 32'sh4, 32'sh5, 32'sh6, 32'sh7, 32'sh8,
                        32'sh9});
    matrix_q.push_back({32'sh1, 32'sh0, 32'sh0, 32'sh0, 32'sh7fffffff, 32'sh0, 32'sh0,
                        32'sh0, 32'sh80000000});
    for (int i = 0; i < NumItems; i++) matrix_q.push_back(rand_matrix());
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    wait (matrix_q.size() == 0 && !in_valid_i);
    wait (inverse_q.size() == 0);
    repeat (TailCycles) @(posedge clk_i);
    if (num_errors == 0 && !out_valid_o) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin
    #2ms;
    $display("== FAIL ==");
    $finish;
  end

endmodule

// ===== files.f =====
hdl/m3inv_pkg.sv
hdl/m3inv_cof.sv
hdl/m3inv_det.sv
hdl/m3inv_div.sv
hdl/matrix3x3_inverse.sv
tb/matrix3x3_inverse_test.sv
